>>> sv/ptaa_pkg.sv
`default_nettype none

package ptaa_pkg;

   // angle output format and CORDIC depth
   localparam int ANGLE_FRAC_BITS = 6;
   localparam int CORDIC_STEPS    = 16;

   localparam int ACC_FRAC = 20;           // CORDIC angle accumulator, 2^-20 degree
   localparam int ATAN_LEN = 24;
   localparam int N_ITER   = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

   // square root of (tx^2 + ty^2) * 4^(F+1), one result bit per stage
   localparam int SUMSQ_W  = 16;
   localparam int RAD_W    = SUMSQ_W + 2 * ANGLE_FRAC_BITS + 2;
   localparam int ROOT_W   = RAD_W / 2;
   localparam int REM_W    = ROOT_W + 3;

   localparam int N_STAGES = (N_ITER > ROOT_W) ? N_ITER : ROOT_W;

   localparam int CW       = 32;           // CORDIC x, y, z width
   localparam int AZ_W     = 15;
   localparam int ALT_W    = 13;

   localparam logic signed [CW-1:0] HALF_TURN  = CW'(180 * (2 ** ACC_FRAC));
   localparam logic signed [CW-1:0] FULL_TURN  = CW'(360 * (2 ** ACC_FRAC));
   localparam int                   ROUND_SH   = ACC_FRAC - ANGLE_FRAC_BITS;
   localparam logic [CW-1:0]        ROUND_HALF = CW'(2 ** (ROUND_SH - 1));
   localparam logic [CW-1:0]        AZ_LIM     = CW'(360 * (2 ** ANGLE_FRAC_BITS));
   localparam logic [ROOT_W:0]      ALT_TOP    = (ROOT_W + 1)'(90 * (2 ** ANGLE_FRAC_BITS));
   localparam logic [ALT_W-1:0]     ALT_TOP_OUT = ALT_W'(ALT_TOP);

   // field_valid bits
   localparam int FV_PRESSURE = 0;
   localparam int FV_ROTATION = 1;
   localparam int FV_TILT_X   = 2;
   localparam int FV_TILT_Y   = 3;
   // pen_flags bits
   localparam int PF_BARREL   = 0;
   localparam int PF_ERASER   = 1;
   localparam int PF_INVERTED = 2;
   // button_mask bits
   localparam int BTN_BARREL  = 0;
   localparam int BTN_ERASER  = 1;

   localparam int REQ_BITS = 32 + 32 + 11 + 8 + 8 + 9 + 4 + 3;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = 32 + 32 + 11 + 8 + 8 + 9 + AZ_W + ALT_W + 2 + 1;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   typedef struct packed {
      logic [REQ_W-REQ_BITS-1:0] pad;
      logic [2:0]                pen_flags;
      logic [3:0]                field_valid;
      logic [8:0]                rotation_in;
      logic signed [7:0]         tilt_y_in;
      logic signed [7:0]         tilt_x_in;
      logic [10:0]               pressure_in;
      logic signed [31:0]        pos_y;
      logic signed [31:0]        pos_x;
   } req_data_type;

   typedef struct packed {
      logic [RSP_W-RSP_BITS-1:0] pad;
      logic                      eraser_cursor;
      logic [1:0]                button_mask;
      logic [ALT_W-1:0]          altitude_out;
      logic [AZ_W-1:0]           azimuth_out;
      logic [8:0]                twist_out;
      logic signed [7:0]         tilt_y_out;
      logic signed [7:0]         tilt_x_out;
      logic [10:0]               pressure_out;
      logic signed [31:0]        pos_y_out;
      logic signed [31:0]        pos_x_out;
   } rsp_data_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic                 zero;
   } cordic_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } root_type;

   // atan(2^-i) in 2^-20 degree, rounded
   function automatic logic signed [CW-1:0] atan_deg(input int idx);
      logic signed [CW-1:0] v;
      case (idx)
         0:  v = CW'(47185920);
         1:  v = CW'(27855475);
         2:  v = CW'(14718068);
         3:  v = CW'(7471121);
         4:  v = CW'(3750058);
         5:  v = CW'(1876857);
         6:  v = CW'(938658);
         7:  v = CW'(469357);
         8:  v = CW'(234682);
         9:  v = CW'(117342);
         10: v = CW'(58671);
         11: v = CW'(29335);
         12: v = CW'(14668);
         13: v = CW'(7334);
         14: v = CW'(3667);
         15: v = CW'(1833);
         16: v = CW'(917);
         17: v = CW'(458);
         18: v = CW'(229);
         19: v = CW'(115);
         20: v = CW'(57);
         21: v = CW'(29);
         22: v = CW'(14);
         23: v = CW'(7);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

>>> sv/pen_tilt_to_azimuth_altitude.sv
// Pipeline: entry stage, one stage per CORDIC iteration / root bit (16 CORDIC iterations
//   and a 15-bit root by default), then the fold-and-round output register.
// Throughput: one sample per cycle; the whole pipe holds on an output stall, and a
//   one-entry skid buffer on the input keeps req_tready a registered signal.
// Reset (synchronous, active high) empties the pipe, the skid buffer and the output.
`default_nettype none

module pen_tilt_to_azimuth_altitude (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // low to high: pos_x[32], pos_y[32], pressure_in[11], tilt_x_in[8], tilt_y_in[8],
   // rotation_in[9], field_valid[4], pen_flags[3], zero pad
   input  logic [ptaa_pkg::REQ_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // low to high: pos_x_out[32], pos_y_out[32], pressure_out[11], tilt_x_out[8],
   // tilt_y_out[8], twist_out[9], azimuth_out[15], altitude_out[13], button_mask[2],
   // eraser_cursor[1], zero pad
   output logic [ptaa_pkg::RSP_W-1:0]    rsp_tdata
);

   localparam int NS = ptaa_pkg::N_STAGES;
   localparam int CW = ptaa_pkg::CW;

   // ---------------------------------------------------------------------------
   // Flow control: every stage moves together when the output register is free
   // or being drained. A transfer that arrives during a stall parks in the skid.
   // ---------------------------------------------------------------------------
   logic                   advance;
   logic                   req_accept;
   logic                   rsp_tvalid_ff;
   logic                   skid_valid_ff, skid_valid_in;
   ptaa_pkg::req_data_type skid_data_ff;
   ptaa_pkg::req_data_type req_data;
   ptaa_pkg::req_data_type ent;
   logic                   ent_valid;

   assign req_data   = req_tdata;
   assign advance    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign ent_valid  = skid_valid_ff || req_accept;
   assign ent        = skid_valid_ff ? skid_data_ff : req_data;

   always_comb begin
      skid_valid_in = skid_valid_ff;
      if (advance) begin
         skid_valid_in = 1'b0;
      end else if (req_accept) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!advance && req_accept) begin
         skid_data_ff <= req_data;
      end
   end

   // ---------------------------------------------------------------------------
   // Pipeline registers: index 0 is the entry stage, 1..NS the iteration stages.
   // ---------------------------------------------------------------------------
   logic                   valid_ff [0:NS];
   ptaa_pkg::rsp_data_type pass_ff  [0:NS];
   ptaa_pkg::cordic_type   cor_ff   [0:NS];
   ptaa_pkg::root_type     root_ff  [0:NS];

   // Entry stage: field masking, sum of squares, CORDIC start vector.
   // The vector (ty, -tx) is turned a half turn up front when ty is negative.
   logic signed [7:0]                 tx, ty;
   logic signed [15:0]                txsq, tysq;
   logic [ptaa_pkg::SUMSQ_W-1:0]      sumsq;
   logic signed [CW-1:0]              tx_sh, ty_sh;
   ptaa_pkg::rsp_data_type            pass_in;
   ptaa_pkg::cordic_type              cor_in;
   ptaa_pkg::root_type                root_in;

   always_comb begin
      tx    = ent.field_valid[ptaa_pkg::FV_TILT_X] ? ent.tilt_x_in : 8'sd0;
      ty    = ent.field_valid[ptaa_pkg::FV_TILT_Y] ? ent.tilt_y_in : 8'sd0;
      txsq  = tx * tx;
      tysq  = ty * ty;
      sumsq = ptaa_pkg::SUMSQ_W'(unsigned'(txsq)) + ptaa_pkg::SUMSQ_W'(unsigned'(tysq));
      tx_sh = {{(CW-8){tx[7]}}, tx} <<< ptaa_pkg::ACC_FRAC;
      ty_sh = {{(CW-8){ty[7]}}, ty} <<< ptaa_pkg::ACC_FRAC;

      cor_in.x    = ty[7] ? -ty_sh : ty_sh;
      cor_in.y    = ty[7] ? tx_sh : -tx_sh;
      cor_in.z    = ty[7] ? ptaa_pkg::HALF_TURN : '0;
      cor_in.zero = (tx == 8'sd0) && (ty == 8'sd0);

      root_in.rad  = ptaa_pkg::RAD_W'(sumsq) << (2 * ptaa_pkg::ANGLE_FRAC_BITS + 2);
      root_in.rem  = '0;
      root_in.root = '0;

      pass_in              = '0;
      pass_in.pos_x_out    = ent.pos_x;
      pass_in.pos_y_out    = ent.pos_y;
      pass_in.pressure_out = ent.field_valid[ptaa_pkg::FV_PRESSURE] ? ent.pressure_in : '0;
      pass_in.tilt_x_out   = tx;
      pass_in.tilt_y_out   = ty;
      pass_in.twist_out    = ent.field_valid[ptaa_pkg::FV_ROTATION] ? ent.rotation_in : '0;
      pass_in.button_mask[ptaa_pkg::BTN_BARREL] = ent.pen_flags[ptaa_pkg::PF_BARREL];
      pass_in.button_mask[ptaa_pkg::BTN_ERASER] = ent.pen_flags[ptaa_pkg::PF_ERASER];
      pass_in.eraser_cursor = ent.pen_flags[ptaa_pkg::PF_INVERTED];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= ent_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pass_ff[0] <= pass_in;
         cor_ff[0]  <= cor_in;
         root_ff[0] <= root_in;
      end
   end

   // Iteration stages: stage k runs CORDIC iteration k-1 (shift by k-1) while k-1 < N_ITER and
   // settles root bit k-1, counted from the top, while k-1 < ROOT_W; else it passes state on.
   for (genvar k = 1; k <= NS; k++) begin : g_stage
      ptaa_pkg::cordic_type cor_step_in;
      ptaa_pkg::root_type   root_step_in;

      if (k - 1 < ptaa_pkg::N_ITER) begin : g_cordic
         logic signed [CW-1:0] xs, ys;
         always_comb begin
            xs          = cor_ff[k-1].x >>> (k - 1);
            ys          = cor_ff[k-1].y >>> (k - 1);
            cor_step_in = cor_ff[k-1];
            // rotate towards y = 0, accumulating the angle turned
            if (!cor_ff[k-1].y[CW-1]) begin
               cor_step_in.x = cor_ff[k-1].x + ys;
               cor_step_in.y = cor_ff[k-1].y - xs;
               cor_step_in.z = cor_ff[k-1].z + ptaa_pkg::atan_deg(k - 1);
            end else begin
               cor_step_in.x = cor_ff[k-1].x - ys;
               cor_step_in.y = cor_ff[k-1].y + xs;
               cor_step_in.z = cor_ff[k-1].z - ptaa_pkg::atan_deg(k - 1);
            end
         end
      end else begin : g_cordic_hold
         assign cor_step_in = cor_ff[k-1];
      end

      if (k - 1 < ptaa_pkg::ROOT_W) begin : g_root
         logic [ptaa_pkg::REM_W-1:0] cur, trial;
         always_comb begin
            cur          = {root_ff[k-1].rem[ptaa_pkg::REM_W-3:0],
                            root_ff[k-1].rad[ptaa_pkg::RAD_W-1 -: 2]};
            trial        = ptaa_pkg::REM_W'({root_ff[k-1].root, 2'b01});
            root_step_in.rad = root_ff[k-1].rad << 2;
            if (cur >= trial) begin
               root_step_in.rem  = cur - trial;
               root_step_in.root = {root_ff[k-1].root[ptaa_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               root_step_in.rem  = cur;
               root_step_in.root = {root_ff[k-1].root[ptaa_pkg::ROOT_W-2:0], 1'b0};
            end
         end
      end else begin : g_root_hold
         assign root_step_in = root_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            pass_ff[k] <= pass_ff[k-1];
            cor_ff[k]  <= cor_step_in;
            root_ff[k] <= root_step_in;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Output stage: fold the angle into one turn, round to 2^-F degree, wrap a
   // full turn to zero; altitude is 90 degrees less the rounded magnitude.
   // ---------------------------------------------------------------------------
   logic signed [CW-1:0]      z_fold;
   logic [CW-1:0]             z_rnd, az_full;
   logic [ptaa_pkg::ROOT_W:0] mag_sum, mag, alt_full;
   ptaa_pkg::rsp_data_type    rsp_data_in, rsp_data_ff;

   always_comb begin
      z_fold   = cor_ff[NS].z[CW-1] ? cor_ff[NS].z + ptaa_pkg::FULL_TURN : cor_ff[NS].z;
      z_rnd    = (unsigned'(z_fold) + ptaa_pkg::ROUND_HALF) >> ptaa_pkg::ROUND_SH;
      az_full  = (z_rnd >= ptaa_pkg::AZ_LIM) ? z_rnd - ptaa_pkg::AZ_LIM : z_rnd;

      mag_sum  = {1'b0, root_ff[NS].root} + (ptaa_pkg::ROOT_W + 1)'(1);
      mag      = mag_sum >> 1;
      alt_full = (mag >= ptaa_pkg::ALT_TOP) ? '0 : ptaa_pkg::ALT_TOP - mag;

      rsp_data_in              = pass_ff[NS];
      rsp_data_in.azimuth_out  = cor_ff[NS].zero ? '0 : ptaa_pkg::AZ_W'(az_full);
      rsp_data_in.altitude_out = ptaa_pkg::ALT_W'(alt_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         rsp_tvalid_ff <= valid_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

>>> sv/ptaa_checker.sv
`default_nettype none

module ptaa_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic [ptaa_pkg::REQ_W-1:0] req_tdata,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [ptaa_pkg::RSP_W-1:0] rsp_tdata
);

   ptaa_pkg::rsp_data_type rsp_view;
   assign rsp_view = rsp_tdata;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // input back-pressure only follows an output stall
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> $past(rsp_tvalid && !rsp_tready))
      else $error("input stalled without output stall");

   // no tilt: straight up, azimuth zero
   a_zero_tilt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_view.tilt_x_out == 8'sd0) && (rsp_view.tilt_y_out == 8'sd0)
      |-> (rsp_view.azimuth_out == '0) && (rsp_view.altitude_out == ptaa_pkg::ALT_TOP_OUT))
      else $error("zero tilt gave wrong angles");

   // keep the request inputs in view for the bind
   logic req_seen;
   assign req_seen = req_tvalid && (req_tdata != '0);
   a_req_data_known: assert property (@(posedge clock) disable iff (reset)
      req_seen |-> req_tvalid)
      else $error("request view inconsistent");

endmodule

bind pen_tilt_to_azimuth_altitude ptaa_checker u_ptaa_checker (.*);

`default_nettype wire
